// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor frame receiver package
// Frame constants and the result record shared by the parser and the top level.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Frame markers.
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] TRAIL_CR   = 8'h0D;
    localparam logic [7:0] TRAIL_LF   = 8'h0A;

    // Frame layout, as byte positions within the frame.
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_HDR2    = 5'd1;
    localparam logic [POS_W-1:0] PAYLOAD_POS = 5'd2;
    localparam logic [POS_W-1:0] SUM_POS     = 5'd15;
    localparam logic [POS_W-1:0] TRAIL_POS   = 5'd16;
    localparam logic [POS_W-1:0] LAST_POS    = 5'd17;
    localparam logic [POS_W-1:0] FRAME_LEN   = 5'd18;

    localparam int PAYLOAD_LEN = 13;
    localparam int PIDX_W      = $clog2(PAYLOAD_LEN);

    // One decoded frame.
    typedef struct packed {
        logic [15:0] distance;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
        logic [15:0] light_level;
        logic [7:0]  gas_level;
        logic        frame_error;
    } sfr_result_t;

endpackage

// ===== sv/sfr_parser.sv =====
// ----------------------------------------------------------------------------
// Sensor frame parser
// Hunts for the header, stores the payload, keeps the running checksum and
// builds the result on the last byte of a frame.
// ----------------------------------------------------------------------------
module sfr_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_en,
    input  logic [7:0]          data_byte,
    output logic                frame_last,
    output sfr_pkg::sfr_result_t result
);

    typedef enum logic [1:0] {
        HUNT_WAIT1 = 2'd0,
        HUNT_WAIT2 = 2'd1,
        HUNT_BODY  = 2'd2
    } hunt_state_t;

    hunt_state_t                 state_reg, state_next;
    logic [sfr_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [7:0]                  rx_sum_reg;
    logic [7:0]                  trail_reg;
    logic [7:0]                  payload_reg [sfr_pkg::PAYLOAD_LEN];

    logic                        pos_ok;
    logic                        store_we;
    logic                        rx_sum_we;
    logic                        trail_we;
    logic [sfr_pkg::POS_W-1:0]   store_off;
    logic [sfr_pkg::PIDX_W-1:0]  store_idx;
    logic                        frame_ok;

    assign pos_ok    = (pos_reg >= sfr_pkg::PAYLOAD_POS) && (pos_reg < sfr_pkg::FRAME_LEN);
    assign store_off = pos_reg - sfr_pkg::PAYLOAD_POS;
    assign store_idx = store_off[sfr_pkg::PIDX_W-1:0];

    // The current byte closes a frame.
    assign frame_last = (state_reg == HUNT_BODY) && (pos_reg == sfr_pkg::LAST_POS);

    // Hunt state machine and byte bookkeeping.
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        rx_sum_we  = 1'b0;
        trail_we   = 1'b0;
        if (byte_en) begin
            unique case (state_reg)
                HUNT_WAIT2: begin
                    if (data_byte == sfr_pkg::HDR_SECOND) begin
                        state_next = HUNT_BODY;
                        pos_next   = sfr_pkg::PAYLOAD_POS;
                        sum_next   = 8'd0;
                    end else begin
                        state_next = HUNT_WAIT1;
                    end
                end
                HUNT_BODY: begin
                    if (!pos_ok) begin
                        state_next = HUNT_WAIT1;
                    end else begin
                        if (pos_reg < sfr_pkg::SUM_POS) begin
                            store_we = 1'b1;
                            sum_next = sum_reg + data_byte;
                        end
                        rx_sum_we = (pos_reg == sfr_pkg::SUM_POS);
                        trail_we  = (pos_reg == sfr_pkg::TRAIL_POS);
                        if (pos_reg == sfr_pkg::LAST_POS) begin
                            pos_next   = sfr_pkg::FRAME_LEN;
                            state_next = HUNT_WAIT1;
                        end else begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end
                end
                default: begin
                    if (data_byte == sfr_pkg::HDR_FIRST) begin
                        state_next = HUNT_WAIT2;
                        pos_next   = sfr_pkg::POS_HDR2;
                    end
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HUNT_WAIT1;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // Payload, checksum and trailer capture.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            payload_reg[store_idx] <= data_byte;
        end
        if (rx_sum_we) begin
            rx_sum_reg <= data_byte;
        end
        if (trail_we) begin
            trail_reg <= data_byte;
        end
    end

    // Frame check and little-endian field assembly.
    assign frame_ok = (sum_reg == rx_sum_reg) && (trail_reg == sfr_pkg::TRAIL_CR)
                      && (data_byte == sfr_pkg::TRAIL_LF);

    always_comb begin
        result = '0;
        if (frame_ok) begin
            result.distance         = {payload_reg[1], payload_reg[0]};
            result.temperature_bits = {payload_reg[5], payload_reg[4],
                                       payload_reg[3], payload_reg[2]};
            result.humidity_bits    = {payload_reg[9], payload_reg[8],
                                       payload_reg[7], payload_reg[6]};
            result.light_level      = {payload_reg[11], payload_reg[10]};
            result.gas_level        = payload_reg[12];
        end else begin
            result.frame_error = 1'b1;
        end
    end

endmodule

// ===== sv/sensor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Sensor frame receiver
// Takes one byte per transaction, finds 18-byte sensor frames and returns
// one decoded result per completed frame.
// A frame's result is registered as its last byte leaves the input register.
// Throughput: one byte per cycle, set by the parser step, but for the stall below.
// A closing byte waits in the input register while the previous result is unaccepted.
// Reset: synchronous active-low aresetn returns the hunt to the first header.
// ----------------------------------------------------------------------------
module sensor_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_distance,
    output logic [31:0] m_temperature_bits,
    output logic [31:0] m_humidity_bits,
    output logic [15:0] m_light_level,
    output logic [7:0]  m_gas_level,
    output logic        m_frame_error
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    sfr_pkg::sfr_result_t out_reg;

    logic                 frame_last;
    sfr_pkg::sfr_result_t result;
    logic                 out_free;
    logic                 step;

    // A byte steps through the parser unless it closes a frame and the
    // result register is still occupied.
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && (!frame_last || out_free);
    assign s_ready  = !in_valid_reg || step;

    sfr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (step),
        .data_byte  (in_byte_reg),
        .frame_last (frame_last),
        .result     (result)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && frame_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && frame_last) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_distance         = out_reg.distance;
    assign m_temperature_bits = out_reg.temperature_bits;
    assign m_humidity_bits    = out_reg.humidity_bits;
    assign m_light_level      = out_reg.light_level;
    assign m_gas_level        = out_reg.gas_level;
    assign m_frame_error      = out_reg.frame_error;

endmodule
